// ===== sv/bpms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// battery power mode selector: shared widths, register indexes, mode codes
// and register reset values. no dependencies.

package bpms_pkg;

    localparam int VOLTAGE_BITS         = 16;
    localparam int WEIGHT_FRACTION_BITS = 15;
    localparam int WEIGHT_BITS          = WEIGHT_FRACTION_BITS + 1;
    localparam int CFG_DATA_BITS        = 16;
    localparam int CFG_INDEX_BITS       = 3;
    localparam int REG_COUNT            = 7;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE =
        WEIGHT_BITS'(1) << WEIGHT_FRACTION_BITS;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WEIGHT      = 3'd0,
        CFG_DOWN_SAFE   = 3'd1,
        CFG_DOWN_CRUISE = 3'd2,
        CFG_DOWN_FULL   = 3'd3,
        CFG_UP_SAFE     = 3'd4,
        CFG_UP_CRUISE   = 3'd5,
        CFG_UP_FULL     = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_CRITICAL = 2'd0,
        MODE_SAFE     = 2'd1,
        MODE_CRUISE   = 2'd2,
        MODE_FULL     = 2'd3
    } mode_t;

    typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;

    localparam cfg_word_t REG_RESET [REG_COUNT] = '{
        16'd16384, 16'd6500, 16'd7000, 16'd7400, 16'd7100, 16'd7500, 16'd7900
    };

endpackage

`default_nettype wire

// ===== sv/bpms_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// sample channel: valid/ready handshake carrying one battery sample word.
// depends on bpms_pkg for the voltage width.

interface bpms_sample_if;
    import bpms_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [VOLTAGE_BITS-1:0] battery_sample;

    modport source (output valid, output battery_sample, input ready);
    modport sink   (input valid, input battery_sample, output ready);
endinterface

`default_nettype wire

// ===== sv/bpms_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// result channel: valid/ready handshake carrying filtered level, mode and
// entry request. depends on bpms_pkg for widths.

interface bpms_result_if;
    import bpms_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [VOLTAGE_BITS-1:0] filtered_level;
    logic [1:0]              power_mode;
    logic                    mode_entry_request;

    modport source (output valid, output filtered_level, output power_mode,
                    output mode_entry_request, input ready);
    modport sink   (input valid, input filtered_level, input power_mode,
                    input mode_entry_request, output ready);
endinterface

`default_nettype wire

// ===== sv/battery_power_mode_selector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// battery power mode selector top level: ema filter plus hysteresis mode pick.
// depends on bpms_pkg, bpms_sample_if and bpms_result_if.
//
// channel   kind        width  contents
// sample    sink        16     battery_sample (mV)
// result    source      19     filtered_level, power_mode, mode_entry_request
// cfg       write port  3+16   cfg_we, cfg_index, cfg_data
//
// one sample per cycle sustained unless the result stalls; a sample passes
// the input register, then filter and compare into the result register.
// filter state and mode update when a word moves into the result register,
// so each sample sees the state left by the one before it.
// a stalled result holds; one more sample waits in the input register.
// reset clears the seed flag, zeroes the average, sets full mode and
// loads the register defaults.

module battery_power_mode_selector (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bpms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [bpms_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    bpms_sample_if.sink                          sample,
    bpms_result_if.source                        result
);
    import bpms_pkg::*;

    localparam int PROD_BITS = WEIGHT_BITS + VOLTAGE_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;

    cfg_word_t               cfg_reg [REG_COUNT];

    logic                    in_valid_reg;
    logic [VOLTAGE_BITS-1:0] sample_reg;

    logic                    out_valid_reg;
    logic [VOLTAGE_BITS-1:0] level_reg;
    mode_t                   out_mode_reg;
    logic                    request_reg;

    logic [VOLTAGE_BITS-1:0] smoothed_reg;
    logic                    seeded_reg;
    mode_t                   mode_reg;

    logic                    in_accept;
    logic                    out_load;
    logic [WEIGHT_BITS-1:0]  weight;
    logic [PROD_BITS-1:0]    prod_new;
    logic [PROD_BITS-1:0]    prod_old;
    logic [SUM_BITS-1:0]     sum;
    logic [VOLTAGE_BITS-1:0] filtered;
    logic [VOLTAGE_BITS-1:0] level_next;
    mode_t                   mode_next;
    logic                    request_next;

    // handshake and stage movement
    assign out_load     = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || out_load;
    assign in_accept    = sample.valid && sample.ready;

    assign result.valid              = out_valid_reg;
    assign result.filtered_level     = level_reg;
    assign result.power_mode         = out_mode_reg;
    assign result.mode_entry_request = request_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                cfg_reg[i] <= REG_RESET[i];
            end
        end
        else if (cfg_we && (cfg_index <= CFG_UP_FULL))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // weight saturates at one
    assign weight = (cfg_reg[CFG_WEIGHT] > CFG_DATA_BITS'(WEIGHT_ONE))
                    ? WEIGHT_ONE : WEIGHT_BITS'(cfg_reg[CFG_WEIGHT]);

    assign prod_new = PROD_BITS'(weight) * PROD_BITS'(sample_reg);
    assign prod_old = PROD_BITS'(WEIGHT_ONE - weight) * PROD_BITS'(smoothed_reg);
    assign sum      = SUM_BITS'(prod_new) + SUM_BITS'(prod_old);
    assign filtered = sum[WEIGHT_FRACTION_BITS +: VOLTAGE_BITS];

    always_comb
    begin
        mode_next    = mode_reg;
        request_next = 1'b0;
        level_next   = filtered;
        if (!seeded_reg)
        begin
            level_next = sample_reg;
        end
        else if (filtered < smoothed_reg)
        begin
            // falling: lowest threshold first
            if (filtered < cfg_reg[CFG_DOWN_SAFE])
            begin
                mode_next    = MODE_CRITICAL;
                request_next = 1'b1;
            end
            else if (filtered < cfg_reg[CFG_DOWN_CRUISE])
            begin
                mode_next    = MODE_SAFE;
                request_next = 1'b1;
            end
            else if (filtered < cfg_reg[CFG_DOWN_FULL])
            begin
                mode_next    = MODE_CRUISE;
                request_next = 1'b1;
            end
        end
        else if (filtered > smoothed_reg)
        begin
            // rising: highest threshold first
            if (filtered > cfg_reg[CFG_UP_FULL])
            begin
                mode_next    = MODE_FULL;
                request_next = 1'b1;
            end
            else if (filtered > cfg_reg[CFG_UP_CRUISE])
            begin
                mode_next    = MODE_CRUISE;
                request_next = 1'b1;
            end
            else if (filtered > cfg_reg[CFG_UP_SAFE])
            begin
                mode_next    = MODE_SAFE;
                request_next = 1'b1;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample.battery_sample;
        end
    end

    // result register and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            smoothed_reg  <= '0;
            seeded_reg    <= 1'b0;
            mode_reg      <= MODE_FULL;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                smoothed_reg  <= level_next;
                seeded_reg    <= 1'b1;
                mode_reg      <= mode_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            level_reg    <= level_next;
            out_mode_reg <= mode_next;
            request_reg  <= request_next;
        end
    end

    // once seeded, the average stays seeded until reset
    a_seed_holds: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |=> seeded_reg)
        else $error("seed flag dropped without reset");

    // the mode only moves on a word that carries an entry request
    a_mode_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_load && request_next) |=> mode_reg == $past(mode_reg))
        else $error("mode changed without entry request");

    // the first word after reset passes the sample through with no request
    a_seed_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !seeded_reg) |=> (level_reg == $past(sample_reg)) && !request_reg)
        else $error("seeding word altered");

    // a pending sample moves on whenever the result side has room
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("input stage stuck with empty result register");

    // reported mode always follows the held mode
    a_mode_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_mode_reg == mode_reg)
        else $error("reported mode differs from held mode");

endmodule

`default_nettype wire
